// ===== hw/rtl/mhs_pkg.sv =====
// shared types and constants of the mail header scanner
package mhs_pkg;

  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned OFFSET_BITS = 24;

  localparam logic [BYTE_BITS-1:0] CHAR_TAB   = 8'd9;
  localparam logic [BYTE_BITS-1:0] CHAR_LF    = 8'd10;
  localparam logic [BYTE_BITS-1:0] CHAR_VT    = 8'd11;
  localparam logic [BYTE_BITS-1:0] CHAR_FF    = 8'd12;
  localparam logic [BYTE_BITS-1:0] CHAR_CR    = 8'd13;
  localparam logic [BYTE_BITS-1:0] CHAR_SPACE = 8'd32;
  localparam logic [BYTE_BITS-1:0] CHAR_COLON = 8'd58;

  // classification of one output word
  typedef enum logic [1:0] {
    KIND_DROP     = 2'd0,
    KIND_NAME     = 2'd1,
    KIND_CONTENTS = 2'd2
  } kind_t;

  // scan mode, one-hot
  typedef enum logic [4:0] {
    SEEK_NAME     = 5'b00001,
    READ_NAME     = 5'b00010,
    SEEK_CONTENTS = 5'b00100,
    READ_CONTENTS = 5'b01000,
    WAIT_LF       = 5'b10000
  } mode_t;

  // scanner state apart from the byte position
  typedef struct packed {
    mode_t mode;
    logic  header_pending;
    logic  contents_started;
    logic  name_started;
    logic  stopped;
  } scan_state_t;

  // one result word
  typedef struct packed {
    logic [BYTE_BITS-1:0]   out_byte;
    kind_t                  out_kind;
    logic                   header_end;
    logic                   headers_done;
    logic [OFFSET_BITS-1:0] body_offset;
    logic                   scan_error;
  } scan_result_t;

  function automatic logic is_ws(input logic [BYTE_BITS-1:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_VT) ||
           (c == CHAR_FF) || (c == CHAR_CR);
  endfunction

  function automatic logic [BYTE_BITS-1:0] map_tab(input logic [BYTE_BITS-1:0] c);
    return (c == CHAR_TAB) ? CHAR_SPACE : c;
  endfunction

endpackage

// ===== hw/rtl/mhs_in_if.sv =====
// input byte channel of the mail header scanner
interface mhs_in_if;
  import mhs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hw/rtl/mhs_out_if.sv =====
// result channel of the mail header scanner
interface mhs_out_if;
  import mhs_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [BYTE_BITS-1:0]   out_byte;
  logic [1:0]             out_kind;
  logic                   header_end;
  logic                   headers_done;
  logic [OFFSET_BITS-1:0] body_offset;
  logic                   scan_error;

  modport source (output valid, output out_byte, output out_kind, output header_end,
                  output headers_done, output body_offset, output scan_error, input ready);
  modport sink (input valid, input out_byte, input out_kind, input header_end,
                input headers_done, input body_offset, input scan_error, output ready);
endinterface

// ===== hw/rtl/mhs_step.sv =====
// next-state and result logic of the scanner for one byte
module mhs_step #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic [mhs_pkg::BYTE_BITS-1:0] cur_byte,
  input  mhs_pkg::scan_state_t          st,
  input  logic [POSITION_BITS-1:0]      pos,
  output mhs_pkg::scan_state_t          st_nxt,
  output logic [POSITION_BITS-1:0]      pos_nxt,
  output mhs_pkg::scan_result_t         res
);
  import mhs_pkg::*;

  localparam int unsigned EXT_BITS =
    (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;

  logic                     line_end;
  logic                     ws;
  logic [1:0]               off_inc;
  logic [POSITION_BITS-1:0] off_sum;
  logic [EXT_BITS-1:0]      off_ext;
  logic [POSITION_BITS-1:0] pos_inc;
  mode_t                    m;
  logic                     hp;
  logic                     cs;
  logic                     ns;
  logic                     stop;
  logic                     blank;

  assign line_end = (cur_byte == CHAR_LF) || (cur_byte == CHAR_CR);
  assign ws       = is_ws(cur_byte);
  // body starts past the LF, or past CR LF
  assign off_inc  = (cur_byte == CHAR_CR) ? 2'd2 : 2'd1;
  assign off_sum  = POSITION_BITS'(pos + POSITION_BITS'(off_inc));
  assign off_ext  = EXT_BITS'(off_sum);
  assign pos_inc  = POSITION_BITS'(pos + 1'b1);

  always_comb begin
    res     = '0;
    pos_nxt = pos;
    m       = st.mode;
    hp      = st.header_pending;
    cs      = st.contents_started;
    ns      = st.name_started;
    stop    = st.stopped;
    blank   = 1'b0;

    if (st.stopped) begin
      // frozen: all-zero results
    end else if (st.mode == WAIT_LF) begin
      if (cur_byte != CHAR_LF) begin
        res.scan_error = 1'b1;
        stop           = 1'b1;
      end else begin
        m       = SEEK_NAME;
        pos_nxt = pos_inc;
      end
    end else begin
      if (m == SEEK_NAME) begin
        if (cur_byte != CHAR_TAB && cur_byte != CHAR_SPACE) begin
          if (hp) begin
            res.header_end = 1'b1;
            hp             = 1'b0;
            cs             = 1'b0;
          end
          if (line_end) begin
            res.headers_done = 1'b1;
            res.body_offset  = off_ext[OFFSET_BITS-1:0];
            stop             = 1'b1;
            blank            = 1'b1;
          end else begin
            m  = READ_NAME;
            ns = 1'b0;
            cs = 1'b0;
            if (cur_byte != CHAR_COLON) begin
              hp = 1'b1;
            end
          end
        end else begin
          // continuation line
          m = READ_CONTENTS;
        end
      end

      if (!blank) begin
        if (m == READ_NAME) begin
          if (cur_byte == CHAR_COLON) begin
            m = SEEK_CONTENTS;
          end else if (!line_end && (ns || !ws)) begin
            res.out_byte = map_tab(cur_byte);
            res.out_kind = KIND_NAME;
            ns           = 1'b1;
          end
        end else begin
          if (m == SEEK_CONTENTS && (!ws || line_end)) begin
            m = READ_CONTENTS;
          end
          if (m == READ_CONTENTS) begin
            if (line_end) begin
              m = (cur_byte == CHAR_CR) ? WAIT_LF : SEEK_NAME;
            end else if (hp && (cs || !ws)) begin
              res.out_byte = map_tab(cur_byte);
              res.out_kind = KIND_CONTENTS;
              cs           = 1'b1;
            end
          end
        end
        pos_nxt = pos_inc;
      end
    end

    st_nxt.mode             = m;
    st_nxt.header_pending   = hp;
    st_nxt.contents_started = cs;
    st_nxt.name_started     = ns;
    st_nxt.stopped          = stop;
  end

endmodule

// ===== hw/rtl/mail_header_scanner_core.sv =====
// top level of the mail header scanner: input register, scan state and result register
//
// usage:
//   in_bus carries one raw message byte per word (valid/ready, taken when both are high).
//   out_bus gives exactly one result word for every input word, in order: the byte to
//   append with tab mapped to space, its kind (dropped, name, contents), header_end when
//   the previous header closed before this byte, headers_done with body_offset on the
//   blank line, and scan_error when CR is not followed by LF.
// path: a taken word is registered in the input register, scanned by the step logic
//   and its result is registered in the result register.
// throughput: one word per cycle while out_bus.ready is high; the scan state update is
//   a single shallow step between the input register and the result register, so
//   back-to-back words flow.
// stall: when out_bus.ready is low the result register holds; the input register still
//   takes one more word, then in_bus.ready drops until the result is taken.
// reset: rst_n (synchronous, active low) empties both registers and returns the scanner
//   to searching for a header name at byte position zero.
// after headers_done or scan_error every further word yields an all-zero result.
module mail_header_scanner_core #(
  parameter int unsigned POSITION_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  mhs_in_if.sink    in_bus,
  mhs_out_if.source out_bus
);
  import mhs_pkg::*;

  // input stage
  logic                 in_valid_r;
  logic [BYTE_BITS-1:0] in_byte_r;

  // scan state
  scan_state_t              st_r;
  scan_state_t              st_nxt;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;

  // result stage
  logic         out_valid_r;
  scan_result_t res_r;
  scan_result_t res_nxt;

  logic step_go;

  // the held word moves on when the result register is empty or being emptied
  assign step_go      = in_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !in_valid_r || step_go;

  mhs_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .cur_byte(in_byte_r),
    .st      (st_r),
    .pos     (pos_r),
    .st_nxt  (st_nxt),
    .pos_nxt (pos_nxt),
    .res     (res_nxt)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      in_valid_r <= 1'b1;
    end else if (step_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_byte_r <= in_bus.in_byte;
    end
  end

  // scan state advances once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode             <= SEEK_NAME;
      st_r.header_pending   <= 1'b0;
      st_r.contents_started <= 1'b0;
      st_r.name_started     <= 1'b0;
      st_r.stopped          <= 1'b0;
      pos_r                 <= '0;
    end else if (step_go) begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.out_byte     = res_r.out_byte;
  assign out_bus.out_kind     = res_r.out_kind;
  assign out_bus.header_end   = res_r.header_end;
  assign out_bus.headers_done = res_r.headers_done;
  assign out_bus.body_offset  = res_r.body_offset;
  assign out_bus.scan_error   = res_r.scan_error;

endmodule
